// ===== hw/rtl/wfc_pkg.sv =====
// Package for the word frequency counter: FSM state type, status and operation codes.
// No dependencies; imported by the top level and the checker.
`default_nettype none
package wfc_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LEN_RD,
		ST_LEN_CHK,
		ST_CMP_RD,
		ST_CMP_CHK,
		ST_MISS,
		ST_CPY_RD,
		ST_CPY_WR,
		ST_ADD,
		ST_TAL_RD,
		ST_TAL_UPD
	} wfc_state_t;

	localparam logic [2:0] STAT_NONE    = 3'd0;
	localparam logic [2:0] STAT_COUNTED = 3'd1;
	localparam logic [2:0] STAT_ADDED   = 3'd2;
	localparam logic [2:0] STAT_DROPPED = 3'd3;
	localparam logic [2:0] STAT_QUERY   = 3'd4;

	localparam logic OP_TEXT  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [7:0] CHAR_END    = 8'h00;
	localparam logic [7:0] CASE_BIT    = 8'h20;
	localparam logic [31:0] TALLY_MAX  = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

// ===== hw/rtl/wfc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module wfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/word_frequency_counter_top.sv =====
// Word frequency counter top level: byte front end, table scan FSM and memories.
// Depends on wfc_pkg and wfc_ram.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------------
//  item in  | start & !busy         | operation, char_byte
//  result   | result_valid (1 cyc)  | status, entry_index, tally, entries_used, text_done
//  config   | cfg_valid & cfg_ready | cfg_data (table_limit)
//
// A letter or nonzero query byte is absorbed in the idle state. A word or query end scans
// the table one entry at a time through the length RAM (read, then check) and, when
// lengths agree, the letter RAM (read, then check per compared letter); adding a word
// copies it letter by letter (read, then write). Each RAM has one registered read port.
// Reset leaves the table empty with no clearing pass. Results cannot be stalled.
`default_nettype none
module word_frequency_counter_top
	import wfc_pkg::*;
#(
	parameter int TABLE_DEPTH = 64,
	parameter int WORD_BYTES  = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        operation,
	input  wire logic [7:0]  char_byte,
	output logic             result_valid,
	output logic [2:0]       status,
	output logic [5:0]       entry_index,
	output logic [31:0]      tally,
	output logic [6:0]       entries_used,
	output logic             text_done,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  cfg_data
);

	localparam int MAXLEN = WORD_BYTES - 1;
	localparam int LEN_W  = $clog2(WORD_BYTES);
	localparam int IW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW     = $clog2(TABLE_DEPTH + 1);
	localparam int LDEPTH = TABLE_DEPTH * MAXLEN;
	localparam int LAW    = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
	localparam int BDEPTH = 2 * MAXLEN;
	localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
	localparam int CMPW   = (CW > 7) ? CW : 7;

	wfc_state_t state_q, state_d;

	logic [6:0]      limit_q;
	logic [CW-1:0]   live_q;
	logic [LEN_W-1:0] plen_q, qlen_q, wlen_q, pos_q;
	logic            qover_q, closed_q, isq_q, done_q;
	logic [CW-1:0]   ent_q;
	logic [LAW-1:0]  base_q;

	// memory ports
	logic             let_we, buf_we, len_we, tal_we;
	logic [LAW-1:0]   let_waddr, let_raddr;
	logic [7:0]       let_wdata, let_rdata;
	logic [BAW-1:0]   buf_waddr, buf_raddr;
	logic [7:0]       buf_wdata, buf_rdata;
	logic [IW-1:0]    len_waddr, len_raddr, tal_waddr, tal_raddr;
	logic [LEN_W-1:0] len_wdata, len_rdata;
	logic [31:0]      tal_wdata, tal_rdata;

	logic accept, is_letter;
	logic [LEN_W-1:0] plen_eff;
	logic [CW-1:0]    live_eff;
	logic [LEN_W:0]   pos_inc;
	logic [CW:0]      ent_inc;
	logic             room;
	logic [31:0]      tal_next;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign is_letter = ((char_byte >= 8'h41) && (char_byte <= 8'h5A)) ||
		((char_byte >= 8'h61) && (char_byte <= 8'h7A));
	assign plen_eff  = closed_q ? '0 : plen_q;
	assign live_eff  = closed_q ? '0 : live_q;
	assign pos_inc   = (LEN_W+1)'(pos_q) + (LEN_W+1)'(1);
	assign ent_inc   = (CW+1)'(ent_q) + (CW+1)'(1);
	assign room      = (CMPW'(live_q) < CMPW'(limit_q)) && (live_q < CW'(TABLE_DEPTH));
	assign tal_next  = (tal_rdata == TALLY_MAX) ? tal_rdata : tal_rdata + 32'd1;

	// RAM instances
	wfc_ram #(.WIDTH(8), .DEPTH(LDEPTH)) u_letters (
		.clk, .we(let_we), .waddr(let_waddr), .wdata(let_wdata),
		.raddr(let_raddr), .rdata(let_rdata));
	wfc_ram #(.WIDTH(8), .DEPTH(BDEPTH)) u_wordbuf (
		.clk, .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
		.raddr(buf_raddr), .rdata(buf_rdata));
	wfc_ram #(.WIDTH(LEN_W), .DEPTH(TABLE_DEPTH)) u_lengths (
		.clk, .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
		.raddr(len_raddr), .rdata(len_rdata));
	wfc_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_tallies (
		.clk, .we(tal_we), .waddr(tal_waddr), .wdata(tal_wdata),
		.raddr(tal_raddr), .rdata(tal_rdata));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d   = state_q;
		let_we    = 1'b0;
		buf_we    = 1'b0;
		len_we    = 1'b0;
		tal_we    = 1'b0;
		let_waddr = base_q + LAW'(pos_q);
		let_wdata = buf_rdata;
		let_raddr = base_q + LAW'(pos_q);
		buf_waddr = BAW'(plen_eff);
		buf_wdata = char_byte | CASE_BIT;
		buf_raddr = isq_q ? BAW'(MAXLEN) + BAW'(pos_q) : BAW'(pos_q);
		len_waddr = ent_q[IW-1:0];
		len_wdata = wlen_q;
		len_raddr = ent_q[IW-1:0];
		tal_waddr = ent_q[IW-1:0];
		tal_wdata = tal_next;
		tal_raddr = ent_q[IW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (operation == OP_QUERY) begin
						if (char_byte != CHAR_END) begin
							buf_we    = (qlen_q < LEN_W'(MAXLEN));
							buf_waddr = BAW'(MAXLEN) + BAW'(qlen_q);
							buf_wdata = char_byte;
						end else if (!qover_q) begin
							state_d = (live_q == '0) ? ST_MISS : ST_LEN_RD;
						end
					end else if (is_letter) begin
						buf_we = (plen_eff < LEN_W'(MAXLEN));
					end else if (plen_eff != '0) begin
						state_d = (live_eff == '0) ? ST_MISS : ST_LEN_RD;
					end
				end
			end
			ST_LEN_RD:  state_d = ST_LEN_CHK;
			ST_LEN_CHK: begin
				if (len_rdata == wlen_q) begin
					state_d = ST_CMP_RD;
				end else begin
					state_d = (ent_inc == (CW+1)'(live_q)) ? ST_MISS : ST_LEN_RD;
				end
			end
			ST_CMP_RD:  state_d = ST_CMP_CHK;
			ST_CMP_CHK: begin
				if (let_rdata != buf_rdata) begin
					state_d = (ent_inc == (CW+1)'(live_q)) ? ST_MISS : ST_LEN_RD;
				end else if (pos_inc == (LEN_W+1)'(wlen_q)) begin
					state_d = ST_TAL_RD;
				end else begin
					state_d = ST_CMP_RD;
				end
			end
			ST_MISS: begin
				state_d = (!isq_q && room) ? ST_CPY_RD : ST_IDLE;
			end
			ST_CPY_RD: state_d = ST_CPY_WR;
			ST_CPY_WR: begin
				let_we  = 1'b1;
				state_d = (pos_inc == (LEN_W+1)'(wlen_q)) ? ST_ADD : ST_CPY_RD;
			end
			ST_ADD: begin
				len_we    = 1'b1;
				tal_we    = 1'b1;
				tal_wdata = 32'd1;
				state_d   = ST_IDLE;
			end
			ST_TAL_RD:  state_d = ST_TAL_UPD;
			ST_TAL_UPD: begin
				tal_we  = !isq_q;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control registers: word lengths, live count, text state, configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= 7'd64;
			live_q   <= '0;
			plen_q   <= '0;
			qlen_q   <= '0;
			qover_q  <= 1'b0;
			closed_q <= 1'b1;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && operation == OP_QUERY) begin
						if (char_byte != CHAR_END) begin
							if (qlen_q < LEN_W'(MAXLEN)) begin
								qlen_q <= qlen_q + LEN_W'(1);
							end else begin
								qover_q <= 1'b1;
							end
						end else begin
							qlen_q       <= '0;
							qover_q      <= 1'b0;
							result_valid <= qover_q;
						end
					end else if (accept) begin
						closed_q <= 1'b0;
						live_q   <= live_eff;
						if (is_letter) begin
							plen_q <= (plen_eff < LEN_W'(MAXLEN)) ?
								plen_eff + LEN_W'(1) : plen_eff;
						end else begin
							plen_q <= '0;
							if (char_byte == CHAR_END) begin
								closed_q <= 1'b1;
							end
							result_valid <= (plen_eff == '0) && (char_byte == CHAR_END);
						end
					end
				end
				ST_MISS:    result_valid <= isq_q || !room;
				ST_ADD: begin
					live_q       <= live_q + CW'(1);
					result_valid <= 1'b1;
				end
				ST_TAL_UPD: result_valid <= 1'b1;
				default: ;
			endcase
		end
	end

	// scan datapath and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ent_q  <= '0;
				base_q <= '0;
				pos_q  <= '0;
				isq_q  <= (operation == OP_QUERY);
				done_q <= (char_byte == CHAR_END);
				wlen_q <= (operation == OP_QUERY) ? qlen_q : plen_eff;
				status       <= (operation == OP_QUERY) ? STAT_QUERY : STAT_NONE;
				entry_index  <= '0;
				tally        <= '0;
				// a query sees the table as it stands, even after a closed text
				entries_used <= (operation == OP_QUERY) ? 7'(live_q) : 7'(live_eff);
				text_done    <= (operation == OP_TEXT);
			end
			ST_LEN_CHK: begin
				pos_q <= '0;
				if (len_rdata != wlen_q) begin
					ent_q  <= CW'(ent_inc);
					base_q <= base_q + LAW'(MAXLEN);
				end
			end
			ST_CMP_CHK: begin
				if (let_rdata != buf_rdata) begin
					ent_q  <= CW'(ent_inc);
					base_q <= base_q + LAW'(MAXLEN);
				end else begin
					pos_q <= LEN_W'(pos_inc);
				end
			end
			ST_MISS: begin
				pos_q        <= '0;
				status       <= isq_q ? STAT_QUERY : STAT_DROPPED;
				entry_index  <= '0;
				tally        <= '0;
				entries_used <= 7'(live_q);
				text_done    <= !isq_q && done_q;
			end
			ST_CPY_WR: pos_q <= LEN_W'(pos_inc);
			ST_ADD: begin
				status       <= STAT_ADDED;
				entry_index  <= 6'(ent_q);
				tally        <= 32'd1;
				entries_used <= 7'(live_q + CW'(1));
				text_done    <= done_q;
			end
			ST_TAL_UPD: begin
				status       <= isq_q ? STAT_QUERY : STAT_COUNTED;
				entry_index  <= 6'(ent_q);
				tally        <= isq_q ? tal_rdata : tal_next;
				entries_used <= 7'(live_q);
				text_done    <= !isq_q && done_q;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/wfc_checker.sv =====
// Port-level checker for the word frequency counter, bound to the top level.
// Depends on wfc_pkg.
`default_nettype none
module wfc_checker
	import wfc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        busy,
	input wire logic        result_valid,
	input wire logic [2:0]  status,
	input wire logic [5:0]  entry_index,
	input wire logic [31:0] tally
);

	// every scan ends with a result transaction
	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid) else $error("scan ended without result");

	// dropped word carries no entry and no tally
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == STAT_DROPPED) |-> (tally == 32'd0 && entry_index == 6'd0))
		else $error("dropped word with payload");

	// a fresh entry starts at one
	a_added: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == STAT_ADDED) |-> (tally == 32'd1))
		else $error("new entry tally not one");

	// a counted word never shows a zero tally
	a_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == STAT_COUNTED) |-> (tally != 32'd0))
		else $error("counted word with zero tally");

endmodule

bind word_frequency_counter_top wfc_checker u_wfc_checker (
	.clk, .arst_n, .busy, .result_valid, .status, .entry_index, .tally);
`default_nettype wire
